/* sv/im2col_pkg.sv */
package im2col_pkg;

   // sizing of the image store and of the gather limits
   localparam int STORE_WORDS     = 65536;
   localparam int MAX_CHANNELS    = 64;
   localparam int MAX_OUTPUT_SIDE = 1024;

   localparam int STORE_AW = $clog2(STORE_WORDS);
   localparam int CHAN_W   = $clog2(MAX_CHANNELS);

   // field widths
   localparam int WORD_W      = 32;
   localparam int ADDR_W      = 16;
   localparam int POS_W       = 10;
   localparam int PCOL_W      = 14;
   localparam int DIM_W       = 11;
   localparam int KER_W       = 5;
   localparam int PAD_W       = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = DIM_W;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   // register indexes
   localparam csr_index_type CSR_IMAGE_HEIGHT  = 3'd0;
   localparam csr_index_type CSR_IMAGE_WIDTH   = 3'd1;
   localparam csr_index_type CSR_KERNEL_HEIGHT = 3'd2;
   localparam csr_index_type CSR_KERNEL_WIDTH  = 3'd3;
   localparam csr_index_type CSR_PAD_ABOVE     = 3'd4;
   localparam csr_index_type CSR_PAD_BEFORE    = 3'd5;
   localparam csr_index_type CSR_STEP_ROWS     = 3'd6;
   localparam csr_index_type CSR_STEP_COLS     = 3'd7;

   typedef struct packed {
      logic              go;
      logic [PCOL_W-1:0] dividend;
      logic [KER_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [PCOL_W-1:0] quotient;
      logic [KER_W-1:0]  remainder;
   } div_rsp_type;

endpackage

/* sv/im2col_divider.sv */
module im2col_divider (
   input  logic                     clock,
   input  logic                     reset,
   input  im2col_pkg::div_req_type  div_req,
   output im2col_pkg::div_rsp_type  div_rsp
);
   import im2col_pkg::*;

   localparam int CNT_W = $clog2(PCOL_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(PCOL_W - 1);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [KER_W-1:0]  rem_ff;
   logic [PCOL_W-1:0] quo_ff;
   logic [KER_W-1:0]  divisor_ff;

   logic [KER_W:0]    trial;
   logic              fits;

   // restoring division, one quotient bit per cycle
   assign trial = {rem_ff, quo_ff[PCOL_W-1]};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.go) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.go) begin
         rem_ff     <= '0;
         quo_ff     <= div_req.dividend;
         divisor_ff <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? KER_W'(trial - {1'b0, divisor_ff}) : trial[KER_W-1:0];
         quo_ff <= {quo_ff[PCOL_W-2:0], fits};
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

/* sv/im2col_patch_gather.sv */
// im2col patch gather. Holds one channel-major image in a 64K x 32-bit store.
// A load word (req_kind 0) writes one store entry; busy stays low and no
// response follows. A read word (req_kind 1) names an output position and a
// patch column; the block returns the image word under that patch element, or
// zero with rsp_in_padding set when it lies in padding, in a channel past the
// limit or outside the store. A read keeps busy high while the shared
// bit-serial divider splits the patch column, first into kernel column, then
// into kernel row and channel, then through the map, check and address steps,
// one store read and the response. The next word is taken in the cycle after
// the response at the earliest.
// The response is shown for exactly one cycle on rsp_strobe and cannot be
// stalled; the receiver must take it.
// Configuration writes are only legal while busy is low. Never read an entry
// that was not loaded: its contents are undefined.
module im2col_patch_gather (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic                                    req_kind,
   input  logic [im2col_pkg::WORD_W-1:0]           req_pixel_word,
   input  logic [im2col_pkg::ADDR_W-1:0]           req_pixel_address,
   input  logic [im2col_pkg::POS_W-1:0]            req_position_row,
   input  logic [im2col_pkg::POS_W-1:0]            req_position_col,
   input  logic [im2col_pkg::PCOL_W-1:0]           req_patch_column,
   output logic                                    rsp_strobe,
   output logic [im2col_pkg::WORD_W-1:0]           rsp_patch_value,
   output logic                                    rsp_in_padding,
   input  logic                                    csr_write_enable,
   input  im2col_pkg::csr_index_type               csr_index,
   input  logic [im2col_pkg::CSR_DATA_W-1:0]       csr_write_data
);
   import im2col_pkg::*;

   // signed row/column in two's complement; top bit is the sign
   localparam int ROW_W  = POS_W + KER_W + 2;
   localparam int CHIH_W = CHAN_W + DIM_W;
   localparam int BASE_W = ROW_W + 1;
   localparam int FLAT_W = BASE_W + DIM_W + 1;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_DIV_COL = 3'd1;
   localparam logic [2:0] ST_DIV_ROW = 3'd2;
   localparam logic [2:0] ST_MAP     = 3'd3;
   localparam logic [2:0] ST_CHECK   = 3'd4;
   localparam logic [2:0] ST_ADDR    = 3'd5;
   localparam logic [2:0] ST_LOOKUP  = 3'd6;
   localparam logic [2:0] ST_RESP    = 3'd7;

   // configuration registers
   logic [DIM_W-1:0] image_height_ff;
   logic [DIM_W-1:0] image_width_ff;
   logic [KER_W-1:0] kernel_height_ff;
   logic [KER_W-1:0] kernel_width_ff;
   logic [PAD_W-1:0] pad_above_ff;
   logic [PAD_W-1:0] pad_before_ff;
   logic [KER_W-1:0] step_rows_ff;
   logic [KER_W-1:0] step_cols_ff;

   // a zero dimension or stride counts as one
   logic [DIM_W-1:0] ih_eff, iw_eff;
   logic [KER_W-1:0] kh_eff, kw_eff, sr_eff, sc_eff;

   logic [2:0]        state_ff, state_in;
   logic [POS_W-1:0]  prow_ff, pcol_ff;
   logic [KER_W-1:0]  kcol_ff, krow_ff;
   logic [PCOL_W-1:0] chan_ff;
   logic [ROW_W-1:0]  row_ff, col_ff;
   logic [CHIH_W-1:0] chan_ih_ff;
   logic              chan_big_ff;
   logic [BASE_W-1:0] base_ff;
   logic [FLAT_W-1:0] flat_ff;
   logic              pad_ff;
   logic [WORD_W-1:0] rd_data_ff;

   logic [WORD_W-1:0] image_mem [STORE_WORDS];

   logic        accept;
   logic        load_we;
   div_req_type div_req;
   div_rsp_type div_rsp;

   assign ih_eff = (image_height_ff  == '0) ? DIM_W'(1) : image_height_ff;
   assign iw_eff = (image_width_ff   == '0) ? DIM_W'(1) : image_width_ff;
   assign kh_eff = (kernel_height_ff == '0) ? KER_W'(1) : kernel_height_ff;
   assign kw_eff = (kernel_width_ff  == '0) ? KER_W'(1) : kernel_width_ff;
   assign sr_eff = (step_rows_ff     == '0) ? KER_W'(1) : step_rows_ff;
   assign sc_eff = (step_cols_ff     == '0) ? KER_W'(1) : step_cols_ff;

   assign busy    = state_ff != ST_IDLE;
   assign accept  = start && !busy;
   assign load_we = accept && !req_kind &&
                    (32'(req_pixel_address) < 32'(STORE_WORDS));

   // ---------------------------------------------------------------
   // Configuration port: write only, unknown indexes are dropped
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         image_height_ff  <= DIM_W'(1);
         image_width_ff   <= DIM_W'(1);
         kernel_height_ff <= KER_W'(1);
         kernel_width_ff  <= KER_W'(1);
         pad_above_ff     <= '0;
         pad_before_ff    <= '0;
         step_rows_ff     <= KER_W'(1);
         step_cols_ff     <= KER_W'(1);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IMAGE_HEIGHT:  image_height_ff  <= csr_write_data[DIM_W-1:0];
            CSR_IMAGE_WIDTH:   image_width_ff   <= csr_write_data[DIM_W-1:0];
            CSR_KERNEL_HEIGHT: kernel_height_ff <= csr_write_data[KER_W-1:0];
            CSR_KERNEL_WIDTH:  kernel_width_ff  <= csr_write_data[KER_W-1:0];
            CSR_PAD_ABOVE:     pad_above_ff     <= csr_write_data[PAD_W-1:0];
            CSR_PAD_BEFORE:    pad_before_ff    <= csr_write_data[PAD_W-1:0];
            CSR_STEP_ROWS:     step_rows_ff     <= csr_write_data[KER_W-1:0];
            CSR_STEP_COLS:     step_cols_ff     <= csr_write_data[KER_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Image store: one write port for loads, registered read port.
   // Loads finish before any read word can reach the lookup, so the
   // lookup read and a load never touch the same entry in one cycle.
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (load_we) begin
         image_mem[req_pixel_address[STORE_AW-1:0]] <= req_pixel_word;
      end
      rd_data_ff <= image_mem[flat_ff[STORE_AW-1:0]];
   end

   // ---------------------------------------------------------------
   // Patch column split: pc / kw, then (pc / kw) / kh on one divider
   // ---------------------------------------------------------------
   always_comb begin
      div_req.go       = 1'b0;
      div_req.dividend = req_patch_column;
      div_req.divisor  = kw_eff;
      if (state_ff == ST_IDLE) begin
         div_req.go = accept && req_kind;
      end else if (state_ff == ST_DIV_COL) begin
         div_req.go       = div_rsp.done;
         div_req.dividend = div_rsp.quotient;
         div_req.divisor  = kh_eff;
      end
   end

   im2col_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (accept && req_kind) state_in = ST_DIV_COL;
         ST_DIV_COL: if (div_rsp.done) state_in = ST_DIV_ROW;
         ST_DIV_ROW: if (div_rsp.done) state_in = ST_MAP;
         ST_MAP:     state_in = ST_CHECK;
         ST_CHECK:   state_in = ST_ADDR;
         ST_ADDR:    state_in = ST_LOOKUP;
         ST_LOOKUP:  state_in = ST_RESP;
         ST_RESP:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath, one step per state
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            prow_ff <= req_position_row;
            pcol_ff <= req_position_col;
         end
         ST_DIV_COL: begin
            if (div_rsp.done) kcol_ff <= div_rsp.remainder;
         end
         ST_DIV_ROW: begin
            if (div_rsp.done) begin
               krow_ff <= div_rsp.remainder;
               chan_ff <= div_rsp.quotient;
            end
         end
         ST_MAP: begin
            row_ff <= ROW_W'(prow_ff) * ROW_W'(sr_eff) + ROW_W'(krow_ff)
                      - ROW_W'(pad_above_ff);
            col_ff <= ROW_W'(pcol_ff) * ROW_W'(sc_eff) + ROW_W'(kcol_ff)
                      - ROW_W'(pad_before_ff);
            chan_ih_ff  <= CHIH_W'(chan_ff[CHAN_W-1:0]) * CHIH_W'(ih_eff);
            chan_big_ff <= 32'(chan_ff) >= 32'(MAX_CHANNELS);
         end
         ST_CHECK: begin
            pad_ff <= row_ff[ROW_W-1] ||
                      (row_ff[ROW_W-2:0] >= (ROW_W-1)'(ih_eff)) ||
                      col_ff[ROW_W-1] ||
                      (col_ff[ROW_W-2:0] >= (ROW_W-1)'(iw_eff)) ||
                      chan_big_ff ||
                      (32'(prow_ff) >= 32'(MAX_OUTPUT_SIDE)) ||
                      (32'(pcol_ff) >= 32'(MAX_OUTPUT_SIDE));
            base_ff <= BASE_W'(row_ff[ROW_W-2:0]) + BASE_W'(chan_ih_ff);
         end
         ST_ADDR: begin
            flat_ff <= FLAT_W'(base_ff) * FLAT_W'(iw_eff)
                       + FLAT_W'(col_ff[ROW_W-2:0]);
         end
         ST_LOOKUP: begin
            // element inside the image but past the store end
            if (32'(flat_ff) >= 32'(STORE_WORDS)) pad_ff <= 1'b1;
         end
         ST_RESP: ;
         default: ;
      endcase
   end

   assign rsp_strobe      = state_ff == ST_RESP;
   assign rsp_in_padding  = pad_ff;
   assign rsp_patch_value = pad_ff ? '0 : rd_data_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for more than one cycle");

   a_read_goes_busy: assert property (@(posedge clock) disable iff (reset)
      accept && req_kind |=> busy && !rsp_strobe)
      else $error("read word accepted without entering the gather sequence");

   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      accept && !req_kind |=> !busy && !rsp_strobe)
      else $error("load word caused busy or a response");

   a_strobe_from_lookup: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == ST_LOOKUP)
      else $error("response without a store lookup");

   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_req.go |-> (state_ff == ST_IDLE || state_ff == ST_DIV_COL))
      else $error("divider started outside the split steps");

endmodule

/* bench/tb_top.sv */
module tb_top;
   import im2col_pkg::*;

   // word kinds on req_kind
   localparam bit KIND_LOAD   = 1'b0;
   localparam bit KIND_GATHER = 1'b1;

   localparam int HALF_PERIOD    = 2;
   localparam int RESET_CYCLES   = 6;
   localparam int TIMEOUT_CYCLES = 500_000;
   // settle for longer than a gather holds busy
   localparam int SETTLE_CYCLES  = 40;
   localparam int DRAIN_LIMIT    = 1000;
   localparam int MAX_IDLE_RUN   = 20;
   localparam int REPORT_LIMIT   = 10;
   localparam int PHASE_WORDS    = 95;

   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic              pad;
   } gather_result_type;

   logic                  clock             = 1'b0;
   logic                  reset             = 1'b1;
   logic                  start             = 1'b0;
   logic                  busy;
   logic                  req_kind          = KIND_LOAD;
   logic [WORD_W-1:0]     req_pixel_word    = '0;
   logic [ADDR_W-1:0]     req_pixel_address = '0;
   logic [POS_W-1:0]      req_position_row  = '0;
   logic [POS_W-1:0]      req_position_col  = '0;
   logic [PCOL_W-1:0]     req_patch_column  = '0;
   logic                  rsp_strobe;
   logic [WORD_W-1:0]     rsp_patch_value;
   logic                  rsp_in_padding;
   logic                  csr_write_enable  = 1'b0;
   csr_index_type         csr_index         = CSR_IMAGE_HEIGHT;
   logic [CSR_DATA_W-1:0] csr_write_data    = '0;

   im2col_patch_gather i_dut (.*);

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Shadow of the block: image store, which entries hold a loaded word, and
   // the geometry registers at their reset values.
   // ---------------------------------------------------------------------------
   bit [WORD_W-1:0] image_copy    [STORE_WORDS];
   bit              image_written [STORE_WORDS];

   bit [DIM_W-1:0] rows_cfg     = 11'd1;
   bit [DIM_W-1:0] cols_cfg     = 11'd1;
   bit [KER_W-1:0] krows_cfg    = 5'd1;
   bit [KER_W-1:0] kcols_cfg    = 5'd1;
   bit [PAD_W-1:0] top_pad_cfg  = 4'd0;
   bit [PAD_W-1:0] left_pad_cfg = 4'd0;
   bit [KER_W-1:0] vstep_cfg    = 5'd1;
   bit [KER_W-1:0] hstep_cfg    = 5'd1;

   gather_result_type pending_gathers [$];

   int idle_percent      = 0;
   int mismatches        = 0;
   int loads_sent        = 0;
   int gathers_sent      = 0;
   int responses_checked = 0;
   int settings_applied  = 0;

   // zero in a size or stride register behaves as one
   function automatic longint nonzero_or_one(longint v);
      return (v == 0) ? 1 : v;
   endfunction

   // Flat store address of the patch element, or -1 when it lands in padding,
   // in a channel past the limit, or past the end of the store.
   function automatic longint element_address(bit [POS_W-1:0] prow, bit [POS_W-1:0] pcol,
                                              bit [PCOL_W-1:0] pc);
      longint ih, iw, kh, kw, vs, hs;
      longint patch, kcol, krow, chan, row, col, addr;
      ih    = nonzero_or_one(rows_cfg);
      iw    = nonzero_or_one(cols_cfg);
      kh    = nonzero_or_one(krows_cfg);
      kw    = nonzero_or_one(kcols_cfg);
      vs    = nonzero_or_one(vstep_cfg);
      hs    = nonzero_or_one(hstep_cfg);
      patch = pc;
      kcol  = patch % kw;
      krow  = (patch / kw) % kh;
      chan  = patch / (kw * kh);
      row   = longint'(prow) * vs - longint'(top_pad_cfg) + krow;
      col   = longint'(pcol) * hs - longint'(left_pad_cfg) + kcol;
      if (row < 0 || row >= ih || col < 0 || col >= iw || chan >= MAX_CHANNELS ||
          prow >= MAX_OUTPUT_SIDE || pcol >= MAX_OUTPUT_SIDE)
         return -1;
      addr = (row + chan * ih) * iw + col;
      if (addr >= STORE_WORDS)
         return -1;
      return addr;
   endfunction

   function automatic void flag_mismatch(string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("MISMATCH @%0t: %s", $time, what);
   endfunction

   // ---------------------------------------------------------------------------
   // Response checker: every strobe is matched against the oldest gather still
   // owed. Sampled at the edge that accepts it, so values are pre-edge.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      gather_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_gathers.size() == 0) begin
            flag_mismatch($sformatf("response with nothing owed: value %08h pad %0b",
                                    rsp_patch_value, rsp_in_padding));
         end else begin
            want = pending_gathers.pop_front();
            responses_checked++;
            if (rsp_patch_value !== want.value || rsp_in_padding !== want.pad)
               flag_mismatch($sformatf("expected value %08h pad %0b, got value %08h pad %0b",
                                       want.value, want.pad, rsp_patch_value,
                                       rsp_in_padding));
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Word driver. Random idle cycles go in front of each word, with junk on the
   // request fields while start is low. A word is taken at the first edge that
   // sees start high and busy low; the shadow is updated at that edge.
   // ---------------------------------------------------------------------------
   task automatic idle_gap();
      int run;
      run = 0;
      while (run < MAX_IDLE_RUN && $urandom_range(99) < idle_percent) begin
         start             <= 1'b0;
         req_kind          <= 1'($urandom);
         req_pixel_word    <= $urandom;
         req_pixel_address <= ADDR_W'($urandom);
         req_position_row  <= POS_W'($urandom);
         req_position_col  <= POS_W'($urandom);
         req_patch_column  <= PCOL_W'($urandom);
         @(posedge clock);
         run++;
      end
   endtask

   task automatic send_item(input bit kind, input bit [WORD_W-1:0] word,
                            input bit [ADDR_W-1:0] addr, input bit [POS_W-1:0] prow,
                            input bit [POS_W-1:0] pcol, input bit [PCOL_W-1:0] pc);
      gather_result_type expected;
      longint            at;
      idle_gap();
      start             <= 1'b1;
      req_kind          <= kind;
      req_pixel_word    <= word;
      req_pixel_address <= addr;
      req_position_row  <= prow;
      req_position_col  <= pcol;
      req_patch_column  <= pc;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      if (kind == KIND_LOAD) begin
         image_copy[addr]    = word;
         image_written[addr] = 1'b1;
         loads_sent++;
      end else begin
         at = element_address(prow, pcol, pc);
         expected.pad   = (at < 0);
         expected.value = (at < 0) ? '0 : image_copy[at];
         pending_gathers.insert(pending_gathers.size(), expected);
         gathers_sent++;
      end
   endtask

   // ---------------------------------------------------------------------------
   // Register writes, only with the block idle: start low, nothing owed and a
   // full gather time spent so a late word cannot overlap the writes.
   // ---------------------------------------------------------------------------
   task automatic write_register(input csr_index_type idx, input bit [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         CSR_IMAGE_HEIGHT:  rows_cfg     = data[DIM_W-1:0];
         CSR_IMAGE_WIDTH:   cols_cfg     = data[DIM_W-1:0];
         CSR_KERNEL_HEIGHT: krows_cfg    = data[KER_W-1:0];
         CSR_KERNEL_WIDTH:  kcols_cfg    = data[KER_W-1:0];
         CSR_PAD_ABOVE:     top_pad_cfg  = data[PAD_W-1:0];
         CSR_PAD_BEFORE:    left_pad_cfg = data[PAD_W-1:0];
         CSR_STEP_ROWS:     vstep_cfg    = data[KER_W-1:0];
         CSR_STEP_COLS:     hstep_cfg    = data[KER_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_geometry(input bit [CSR_DATA_W-1:0] height, width, krows, kcols,
                                 top, left, vstep, hstep);
      start <= 1'b0;
      while (pending_gathers.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_register(CSR_IMAGE_HEIGHT,  height);
      write_register(CSR_IMAGE_WIDTH,   width);
      write_register(CSR_KERNEL_HEIGHT, krows);
      write_register(CSR_KERNEL_WIDTH,  kcols);
      write_register(CSR_PAD_ABOVE,     top);
      write_register(CSR_PAD_BEFORE,    left);
      write_register(CSR_STEP_ROWS,     vstep);
      write_register(CSR_STEP_COLS,     hstep);
      csr_write_enable <= 1'b0;
      settings_applied++;
   endtask

   // ---------------------------------------------------------------------------
   // Random phase: set the geometry, load a corner of the image (chans x rows x
   // cols), then a mix of gathers aimed into that corner, gathers with fully
   // random fields, and stray loads anywhere in the store. A gather that would
   // hit a never-loaded entry is redrawn; if none fits, a stray load goes out.
   // ---------------------------------------------------------------------------
   task automatic run_phase(input bit [CSR_DATA_W-1:0] height, width, krows, kcols,
                            top, left, vstep, hstep,
                            input int chans, aim_rows, aim_cols, idle_pct);
      int     ih, iw, kh, kw, vs, hs;
      int     chan, tr, tc, krow, kcol, prow, pcol, pc, tries;
      longint at;
      bit     found;
      idle_percent = idle_pct;
      apply_geometry(height, width, krows, kcols, top, left, vstep, hstep);
      ih = int'(nonzero_or_one(rows_cfg));
      iw = int'(nonzero_or_one(cols_cfg));
      kh = int'(nonzero_or_one(krows_cfg));
      kw = int'(nonzero_or_one(kcols_cfg));
      vs = int'(nonzero_or_one(vstep_cfg));
      hs = int'(nonzero_or_one(hstep_cfg));

      for (int ch = 0; ch < chans; ch++)
         for (int r = 0; r < aim_rows; r++)
            for (int c = 0; c < aim_cols; c++) begin
               at = (longint'(r) + longint'(ch) * ih) * iw + c;
               if (at < STORE_WORDS)
                  send_item(KIND_LOAD, $urandom, at[ADDR_W-1:0], POS_W'($urandom),
                            POS_W'($urandom), PCOL_W'($urandom));
            end

      for (int n = 0; n < PHASE_WORDS; n++) begin
         found = 1'b0;
         if ($urandom_range(99) >= 15) begin
            for (tries = 0; tries < 20 && !found; tries++) begin
               if ($urandom_range(99) < 70) begin
                  // steer the patch element onto a loaded pixel where stride allows
                  chan = $urandom_range(chans - 1);
                  tr   = $urandom_range(aim_rows - 1);
                  tc   = $urandom_range(aim_cols - 1);
                  prow = (tr + top_pad_cfg) / vs;
                  pcol = (tc + left_pad_cfg) / hs;
                  krow = tr + top_pad_cfg - prow * vs;
                  kcol = tc + left_pad_cfg - pcol * hs;
                  if (krow >= kh)
                     krow = $urandom_range(kh - 1);
                  if (kcol >= kw)
                     kcol = $urandom_range(kw - 1);
                  pc = (chan * kh + krow) * kw + kcol;
               end else begin
                  prow = $urandom_range(MAX_OUTPUT_SIDE - 1);
                  pcol = $urandom_range(MAX_OUTPUT_SIDE - 1);
                  pc   = $urandom_range((1 << PCOL_W) - 1);
               end
               at    = element_address(POS_W'(prow), POS_W'(pcol), PCOL_W'(pc));
               found = (at < 0) || image_written[at];
            end
         end
         if (found)
            send_item(KIND_GATHER, $urandom, ADDR_W'($urandom), POS_W'(prow),
                      POS_W'(pcol), PCOL_W'(pc));
         else
            send_item(KIND_LOAD, $urandom, ADDR_W'($urandom), POS_W'($urandom),
                      POS_W'($urandom), PCOL_W'($urandom));
      end
   endtask

   // ---------------------------------------------------------------------------
   // Directed tests
   // ---------------------------------------------------------------------------

   // Reset geometry is a 1x1 image under a 1x1 kernel.
   task automatic test_reset_defaults();
      idle_percent = 0;
      send_item(KIND_LOAD, 32'hFFFF_FFFF, 16'h0000, 10'h3FF, 10'h3FF, 14'h3FFF);
      send_item(KIND_GATHER, 32'h0, 16'hFFFF, 10'd0, 10'd0, 14'd0);
      send_item(KIND_GATHER, 32'h0, 16'hFFFF, 10'd0, 10'd1, 14'd0);     // right of image
      send_item(KIND_GATHER, 32'h0, 16'hFFFF, 10'd0, 10'd0, 14'd64);    // channel past limit
      send_item(KIND_GATHER, 32'h0, 16'hFFFF, 10'h3FF, 10'h3FF, 14'h3FFF);
   endtask

   // 2x3 image, 3x3 kernel, one-pixel border, stride two: every padding edge.
   task automatic test_padding_stride();
      bit [WORD_W-1:0] words [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FC0_0000,
                                     32'h8000_0000, 32'h3F80_0000, 32'h1234_5678};
      idle_percent = 0;
      apply_geometry(11'd2, 11'd3, 11'd3, 11'd3, 11'd1, 11'd1, 11'd2, 11'd2);
      for (int i = 0; i < 6; i++)
         send_item(KIND_LOAD, words[i], ADDR_W'(i), 10'd0, 10'd0, 14'd0);
      send_item(KIND_GATHER, 32'h0, 16'h0, 10'd0, 10'd0, 14'd0);   // above and left
      send_item(KIND_GATHER, 32'h0, 16'h0, 10'd0, 10'd0, 14'd4);   // top-left pixel
      send_item(KIND_GATHER, 32'h0, 16'h0, 10'd0, 10'd1, 14'd5);   // right of image
      send_item(KIND_GATHER, 32'h0, 16'h0, 10'd0, 10'd1, 14'd4);   // top-right pixel
      send_item(KIND_GATHER, 32'h0, 16'h0, 10'd1, 10'd0, 14'd7);   // below image
      send_item(KIND_GATHER, 32'h0, 16'h0, 10'd0, 10'd1, 14'd7);   // second row
   endtask

   // All-zero sizes and strides fall back to one.
   task automatic test_zero_registers();
      idle_percent = 0;
      apply_geometry('0, '0, '0, '0, '0, '0, '0, '0);
      send_item(KIND_GATHER, 32'h0, 16'h0, 10'd0, 10'd0, 14'd0);
      send_item(KIND_GATHER, 32'h0, 16'h0, 10'd0, 10'd1, 14'd0);
      send_item(KIND_GATHER, 32'h0, 16'h0, 10'd0, 10'd0, 14'd1);   // next channel
   endtask

   // 1024x1024 image: last store word, then in-image pixels past the store.
   task automatic test_store_boundary();
      idle_percent = 0;
      apply_geometry(11'd1024, 11'd1024, 11'd1, 11'd1, 11'd0, 11'd0, 11'd1, 11'd1);
      send_item(KIND_LOAD, 32'hA5A5_5A5A, 16'hFFFF, 10'd0, 10'd0, 14'd0);
      send_item(KIND_GATHER, 32'h0, 16'h0, 10'd63, 10'd1023, 14'd0);
      send_item(KIND_GATHER, 32'h0, 16'h0, 10'd64, 10'd0, 14'd0);
      send_item(KIND_GATHER, 32'h0, 16'h0, 10'd0, 10'd0, 14'd1);
   endtask

   // ---------------------------------------------------------------------------
   // Random tests, one geometry each, idle pattern rotating 0 / 74 / 24 %, the last at 74 %
   // ---------------------------------------------------------------------------
   task automatic test_random_unit_kernel();
      run_phase(11'd4, 11'd4, 11'd1, 11'd1, 11'd0, 11'd0, 11'd1, 11'd1, 3, 4, 4, 0);
   endtask

   task automatic test_random_padded_kernel();
      run_phase(11'd5, 11'd7, 11'd3, 11'd3, 11'd1, 11'd1, 11'd1, 11'd1, 2, 5, 7, 74);
   endtask

   task automatic test_random_widest_settings();
      run_phase(11'd6, 11'd6, 11'd16, 11'd16, 11'd15, 11'd15, 11'd16, 11'd16, 1, 6, 6, 24);
   endtask

   // all-ones data: 2047 image sides, 31 kernel and stride, 15 padding
   task automatic test_random_over_range();
      run_phase('1, '1, '1, '1, '1, '1, '1, '1, 1, 4, 8, 0);
   endtask

   task automatic test_random_full_size_image();
      run_phase(11'd1024, 11'd1024, 11'd2, 11'd5, 11'd3, 11'd0, 11'd1, 11'd3, 1, 4, 16, 74);
   endtask

   // 1x1 image in every channel up to the limit, and beyond via random columns
   task automatic test_random_zero_registers();
      run_phase('0, '0, '0, '0, '0, '0, '0, '0, MAX_CHANNELS, 1, 1, 24);
   endtask

   task automatic test_random_mixed_stride();
      run_phase(11'd3, 11'd9, 11'd2, 11'd4, 11'd2, 11'd3, 11'd2, 11'd1, 4, 3, 9, 74);
   endtask

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------
   initial begin
      int guard;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_padding_stride();
      test_zero_registers();
      test_store_boundary();
      test_random_unit_kernel();
      test_random_padded_kernel();
      test_random_widest_settings();
      test_random_over_range();
      test_random_full_size_image();
      test_random_zero_registers();
      test_random_mixed_stride();

      start <= 1'b0;
      guard = 0;
      while (pending_gathers.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_gathers.size() != 0)
         flag_mismatch($sformatf("%0d gather responses never arrived",
                                 pending_gathers.size()));

      $display("Covered %0d load words and %0d gather words over %0d register settings.",
               loads_sent, gathers_sent, settings_applied);
      $display("Checked %0d responses, %0d mismatches.", responses_checked, mismatches);
      if (mismatches == 0)
         $display("im2col_patch_gather regression: pass");
      else
         $display("im2col_patch_gather regression: fail");
      $finish;
   end

   // hard stop in case the block locks up
   initial begin
      #(2 * HALF_PERIOD * TIMEOUT_CYCLES);
      $display("im2col_patch_gather regression: fail");
      $finish;
   end

endmodule
